// ----- rtl/level_crossing_gate_controller_assert.svh -----
// Assertion macros for the crossing controller RTL.
`ifndef LEVEL_CROSSING_GATE_CONTROLLER_ASSERT_SVH
`define LEVEL_CROSSING_GATE_CONTROLLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCGC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LCGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lcgc_pkg.sv -----
package lcgc_pkg;

  localparam int unsigned NUM_ARMS = 4;

  typedef logic [6:0] lcgc_angle_t;

  // Arm order, also the bit position of each arm's raise command.
  localparam int unsigned ARM_RN = 0;
  localparam int unsigned ARM_RS = 1;
  localparam int unsigned ARM_LN = 2;
  localparam int unsigned ARM_LS = 3;

  localparam logic [3:0] RAISE_RN  = 4'b0001;
  localparam logic [3:0] RAISE_RS  = 4'b0010;
  localparam logic [3:0] RAISE_LN  = 4'b0100;
  localparam logic [3:0] RAISE_LS  = 4'b1000;
  localparam logic [3:0] RAISE_ALL = 4'b1111;

  localparam logic [4:0]  COUNT_MAX   = 5'd20;
  localparam lcgc_angle_t ANGLE_RESET = 7'd90;

  // External gate phase codes.
  localparam logic [2:0] PHASE_CODE_OPEN      = 3'd0;
  localparam logic [2:0] PHASE_CODE_ENTERING  = 3'd1;
  localparam logic [2:0] PHASE_CODE_CLOSEWAIT = 3'd2;
  localparam logic [2:0] PHASE_CODE_CLOSED    = 3'd3;
  localparam logic [2:0] PHASE_CODE_REOPEN    = 3'd4;
  localparam logic [2:0] PHASE_CODE_FAULT     = 3'd5;

  // External light codes.
  localparam logic [1:0] LIGHT_GREEN = 2'd0;
  localparam logic [1:0] LIGHT_AMBER = 2'd1;
  localparam logic [1:0] LIGHT_RED   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_RAMP_STEP        = 3'd0;
  localparam logic [2:0] CFG_OPEN_ANGLE       = 3'd1;
  localparam logic [2:0] CFG_FAULT_TIMEOUT    = 3'd2;
  localparam logic [2:0] CFG_CLOSE_WAIT       = 3'd3;
  localparam logic [2:0] CFG_LIGHT_DELAY      = 3'd4;
  localparam logic [2:0] CFG_OPEN_THRESHOLD   = 3'd5;
  localparam logic [2:0] CFG_CLOSED_THRESHOLD = 3'd6;

  typedef struct packed {
    lcgc_angle_t ramp_step;
    lcgc_angle_t open_angle;
    logic [4:0]  fault_timeout;
    logic [4:0]  close_wait;
    logic [2:0]  light_delay;
    lcgc_angle_t open_threshold;
    lcgc_angle_t closed_threshold;
  } lcgc_cfg_t;

  localparam lcgc_cfg_t CFG_RESET = '{
    ramp_step:        7'd10,
    open_angle:       7'd90,
    fault_timeout:    5'd12,
    close_wait:       5'd4,
    light_delay:      3'd4,
    open_threshold:   7'd80,
    closed_threshold: 7'd10
  };

  typedef struct packed {
    logic train_entered;
    logic train_exited;
  } lcgc_in_t;

  typedef struct packed {
    lcgc_angle_t angle_right_north;
    lcgc_angle_t angle_right_south;
    lcgc_angle_t angle_left_north;
    lcgc_angle_t angle_left_south;
    logic [1:0]  light_code;
    logic [2:0]  gate_phase_out;
    logic        alarm_out;
  } lcgc_out_t;

  // Next-tick view of the gate chart.
  typedef struct packed {
    logic [3:0] raise;
    logic [2:0] phase_code;
    logic       alarm;
  } lcgc_gate_t;

endpackage

// ----- rtl/lcgc_gate_ctrl.sv -----
module lcgc_gate_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              first_i,
  input  logic              ent_i,
  input  logic              ext_i,
  input  lcgc_pkg::lcgc_cfg_t cfg_i,
  input  logic              all_open_i,
  input  logic              all_closed_i,
  output lcgc_pkg::lcgc_gate_t gate_o
);
  import lcgc_pkg::*;

  typedef enum logic [5:0] {
    PH_OPEN      = 6'b000001,
    PH_ENTERING  = 6'b000010,
    PH_CLOSEWAIT = 6'b000100,
    PH_CLOSED    = 6'b001000,
    PH_REOPEN    = 6'b010000,
    PH_FAULT     = 6'b100000
  } lcgc_phase_e;

  lcgc_phase_e phase_q, phase_d, last_q, last_d;
  logic [4:0]  tick_q, tick_d, tick_inc;
  logic [3:0]  raise_q, raise_d;
  logic        alarm_q, alarm_d;

  assign tick_inc = (tick_q < COUNT_MAX) ? tick_q + 5'd1 : COUNT_MAX;

  always_comb begin
    phase_d = phase_q;
    last_d  = last_q;
    tick_d  = tick_q;
    raise_d = raise_q;
    alarm_d = alarm_q;
    if (first_i) begin
      phase_d = PH_OPEN;
      raise_d = RAISE_ALL;
      last_d  = PH_OPEN;
      alarm_d = 1'b0;
    end else begin
      case (phase_q)
        PH_CLOSED: begin
          raise_d = raise_q & ~(RAISE_LN | RAISE_RS);
          if (ext_i) begin
            phase_d = PH_REOPEN;
            raise_d = RAISE_ALL;
            last_d  = PH_REOPEN;
            tick_d  = '0;
            alarm_d = 1'b0;
          end else begin
            tick_d = tick_inc;
          end
        end
        PH_REOPEN: begin
          raise_d = RAISE_ALL;
          if (all_open_i) begin
            phase_d = PH_OPEN;
            last_d  = PH_OPEN;
            alarm_d = 1'b0;
          end else if (tick_q > cfg_i.fault_timeout) begin
            phase_d = PH_FAULT;
            alarm_d = 1'b1;
          end else begin
            tick_d = tick_inc;
          end
        end
        PH_OPEN: begin
          raise_d = RAISE_ALL;
          if (ent_i) begin
            phase_d = PH_ENTERING;
            raise_d = RAISE_ALL & ~(RAISE_LS | RAISE_RN);
            last_d  = PH_ENTERING;
            tick_d  = '0;
            alarm_d = 1'b0;
          end
        end
        PH_FAULT: begin
          // Recovery depends on where the fault came from; a fault raised
          // while reopening has no way out.
          if (last_q == PH_ENTERING && all_closed_i) begin
            phase_d = PH_CLOSEWAIT;
            tick_d  = '0;
            last_d  = PH_CLOSEWAIT;
            alarm_d = 1'b0;
          end else if (last_q == PH_CLOSED && ext_i) begin
            phase_d = PH_REOPEN;
            raise_d = RAISE_ALL;
            last_d  = PH_REOPEN;
            tick_d  = '0;
            alarm_d = 1'b0;
          end else begin
            alarm_d = 1'b1;
          end
        end
        PH_CLOSEWAIT: begin
          if (tick_q > cfg_i.close_wait) begin
            phase_d = PH_CLOSED;
            raise_d = raise_q & ~(RAISE_LN | RAISE_RS);
            tick_d  = '0;
            last_d  = PH_CLOSED;
            alarm_d = 1'b0;
          end else begin
            tick_d = tick_inc;
          end
        end
        default: begin
          raise_d = raise_q & ~(RAISE_LS | RAISE_RN);
          if (tick_q > cfg_i.fault_timeout) begin
            phase_d = PH_FAULT;
            alarm_d = 1'b1;
          end else if (all_closed_i) begin
            phase_d = PH_CLOSEWAIT;
            tick_d  = '0;
            last_d  = PH_CLOSEWAIT;
            alarm_d = 1'b0;
          end else begin
            tick_d = tick_inc;
          end
        end
      endcase
    end
  end

  always_comb begin
    case (phase_d)
      PH_OPEN:      gate_o.phase_code = PHASE_CODE_OPEN;
      PH_CLOSEWAIT: gate_o.phase_code = PHASE_CODE_CLOSEWAIT;
      PH_CLOSED:    gate_o.phase_code = PHASE_CODE_CLOSED;
      PH_REOPEN:    gate_o.phase_code = PHASE_CODE_REOPEN;
      PH_FAULT:     gate_o.phase_code = PHASE_CODE_FAULT;
      default:      gate_o.phase_code = PHASE_CODE_ENTERING;
    endcase
  end

  assign gate_o.raise = raise_d;
  assign gate_o.alarm = alarm_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPEN;
      last_q  <= PH_OPEN;
      tick_q  <= '0;
      raise_q <= '0;
      alarm_q <= 1'b0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      last_q  <= last_d;
      tick_q  <= tick_d;
      raise_q <= raise_d;
      alarm_q <= alarm_d;
    end
  end

endmodule

// ----- rtl/lcgc_arm.sv -----
module lcgc_arm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                raise_i,
  input  lcgc_pkg::lcgc_cfg_t cfg_i,
  output lcgc_pkg::lcgc_angle_t angle_o
);
  import lcgc_pkg::*;

  lcgc_angle_t angle_q, angle_d, diff;
  logic [7:0]  sum;
  logic        below_zero;

  assign sum        = {1'b0, angle_q} + {1'b0, cfg_i.ramp_step};
  assign below_zero = angle_q < cfg_i.ramp_step;
  assign diff       = angle_q - cfg_i.ramp_step;

  // Step toward open or closed, then clamp to [0, open_angle].
  always_comb begin
    if (raise_i) begin
      angle_d = (sum > {1'b0, cfg_i.open_angle}) ? cfg_i.open_angle : sum[6:0];
    end else if (below_zero) begin
      angle_d = '0;
    end else begin
      angle_d = (diff > cfg_i.open_angle) ? cfg_i.open_angle : diff;
    end
  end

  assign angle_o = angle_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= ANGLE_RESET;
    end else if (adv_i) begin
      angle_q <= angle_d;
    end
  end

endmodule

// ----- rtl/lcgc_light.sv -----
module lcgc_light (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                first_i,
  input  logic                ent_i,
  input  logic                ext_i,
  input  lcgc_pkg::lcgc_cfg_t cfg_i,
  input  lcgc_pkg::lcgc_angle_t [lcgc_pkg::NUM_ARMS-1:0] angles_i,
  output logic [1:0]          light_code_o,
  output logic                all_open_o
);
  import lcgc_pkg::*;

  typedef enum logic [3:0] {
    LT_GREEN       = 4'b0001,
    LT_AMBER_DELAY = 4'b0010,
    LT_RED         = 4'b0100,
    LT_AMBER_OPEN  = 4'b1000
  } lcgc_light_e;

  lcgc_light_e phase_q, phase_d;
  logic [2:0]  count_q, count_d;
  logic        all_open_q, all_open_d;
  logic        arms_open;

  always_comb begin
    arms_open = 1'b1;
    for (int i = 0; i < NUM_ARMS; i++) begin
      arms_open = arms_open & (angles_i[i] >= cfg_i.open_threshold);
    end
  end

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    all_open_d = all_open_q;
    if (first_i) begin
      phase_d = LT_GREEN;
    end else begin
      case (phase_q)
        LT_GREEN: begin
          if (ent_i) begin
            phase_d = LT_AMBER_DELAY;
            count_d = '0;
          end
        end
        LT_RED: begin
          if (ext_i) begin
            phase_d = LT_AMBER_OPEN;
          end
        end
        LT_AMBER_DELAY: begin
          if (count_q >= cfg_i.light_delay) begin
            phase_d = LT_RED;
          end else begin
            count_d = count_q + 3'd1;
          end
        end
        default: begin
          // The all-open flag is sticky until reset.
          if (arms_open) begin
            phase_d    = LT_GREEN;
            all_open_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    case (phase_d)
      LT_GREEN: light_code_o = LIGHT_GREEN;
      LT_RED:   light_code_o = LIGHT_RED;
      default:  light_code_o = LIGHT_AMBER;
    endcase
  end

  assign all_open_o = all_open_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= LT_GREEN;
      count_q    <= '0;
      all_open_q <= 1'b0;
    end else if (adv_i) begin
      phase_q    <= phase_d;
      count_q    <= count_d;
      all_open_q <= all_open_d;
    end
  end

endmodule

// ----- rtl/level_crossing_gate_controller.sv -----
// A tick accepted into the input register moves into the result register when the
// result slot frees up, and its result can transfer from there.
// Throughput: one tick per clock while results are not stalled; the input and result
// registers let a new tick enter while a finished result still waits to be taken.
// Reset (asynchronous, active low) restores the configuration defaults, all arms
// at 90 degrees, gate phase open, light green and all flags clear.
module level_crossing_gate_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lcgc_pkg::lcgc_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lcgc_pkg::lcgc_out_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [6:0]         cfg_data_i
);
  import lcgc_pkg::*;

  `include "level_crossing_gate_controller_assert.svh"

  lcgc_cfg_t   cfg_q, cfg_d;
  lcgc_in_t    in_q;
  lcgc_out_t   out_q, out_d;
  logic        in_valid_q, in_valid_d;
  logic        out_valid_q, out_valid_d;
  logic        started_q;
  logic        all_closed_q, all_closed_d;
  logic        advance, out_free, in_xfer, first;
  logic        all_open;
  lcgc_gate_t  gate;
  lcgc_angle_t [NUM_ARMS-1:0] angles;
  logic [1:0]  light_code;

  // The tick in the input register moves on when the result slot frees up.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign first      = !started_q;

  assign in_valid_d  = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RAMP_STEP:        cfg_d.ramp_step        = cfg_data_i;
        CFG_OPEN_ANGLE:       cfg_d.open_angle       = cfg_data_i;
        CFG_FAULT_TIMEOUT:    cfg_d.fault_timeout    = cfg_data_i[4:0];
        CFG_CLOSE_WAIT:       cfg_d.close_wait       = cfg_data_i[4:0];
        CFG_LIGHT_DELAY:      cfg_d.light_delay      = cfg_data_i[2:0];
        CFG_OPEN_THRESHOLD:   cfg_d.open_threshold   = cfg_data_i;
        CFG_CLOSED_THRESHOLD: cfg_d.closed_threshold = cfg_data_i;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  lcgc_gate_ctrl u_gate (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (advance),
    .first_i      (first),
    .ent_i        (in_q.train_entered),
    .ext_i        (in_q.train_exited),
    .cfg_i        (cfg_q),
    .all_open_i   (all_open),
    .all_closed_i (all_closed_q),
    .gate_o       (gate)
  );

  for (genvar g = 0; g < NUM_ARMS; g++) begin : g_arm
    lcgc_arm u_arm (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (advance),
      .raise_i (gate.raise[g]),
      .cfg_i   (cfg_q),
      .angle_o (angles[g])
    );
  end

  lcgc_light u_light (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (advance),
    .first_i      (first),
    .ent_i        (in_q.train_entered),
    .ext_i        (in_q.train_exited),
    .cfg_i        (cfg_q),
    .angles_i     (angles),
    .light_code_o (light_code),
    .all_open_o   (all_open)
  );

  // Sampled from the right-north and left-south arms for the next tick.
  assign all_closed_d = (angles[ARM_RN] < cfg_q.closed_threshold) &&
                        (angles[ARM_LS] < cfg_q.closed_threshold);

  always_comb begin
    out_d.angle_right_north = angles[ARM_RN];
    out_d.angle_right_south = angles[ARM_RS];
    out_d.angle_left_north  = angles[ARM_LN];
    out_d.angle_left_south  = angles[ARM_LS];
    out_d.light_code        = light_code;
    out_d.gate_phase_out    = gate.phase_code;
    out_d.alarm_out         = gate.alarm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q        <= CFG_RESET;
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      started_q    <= 1'b0;
      all_closed_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        started_q    <= 1'b1;
        all_closed_q <= all_closed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LCGC_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_q, "advanced tick left no result")
  `LCGC_ASSERT_NOW(a_alarm_only_in_fault, out_valid_q && out_q.alarm_out,
    out_q.gate_phase_out == PHASE_CODE_FAULT, "alarm raised outside the fault phase")
  `LCGC_ASSERT_NOW(a_stall_needs_backlog, in_stall_o,
    in_valid_q && out_valid_q && out_stall_i, "input stalled without a backlog")
  `LCGC_ASSERT_NEXT(a_first_tick_open, advance && !started_q,
    out_q.gate_phase_out == PHASE_CODE_OPEN && !out_q.alarm_out, "first tick not open")

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import lcgc_pkg::*;

  localparam logic [2:0]  CFG_INDEX_UNUSED = 3'd7;
  localparam int unsigned TICK_TARGET      = 1650;
  localparam int unsigned SEGMENT_TICKS    = 130;
  localparam int unsigned SETTLE_CYCLES    = 6;
  localparam int unsigned CYCLE_LIMIT      = 200000;

  typedef enum logic [1:0] {
    LAMP_GREEN,
    LAMP_DELAY,
    LAMP_RED,
    LAMP_CLEARING
  } lamp_state_e;

  typedef enum int {
    SET_TAME,
    SET_FLOOR,
    SET_CEILING,
    SET_WILD
  } cfg_flavor_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  lcgc_in_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  lcgc_out_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [6:0]  cfg_data_i  = '0;

  bit          no_idle     = 1'b0;
  int unsigned ticks_sent  = 0;
  int unsigned cycle_count = 0;
  int          fail_count  = 0;
  lcgc_out_t   pending_outputs[$];

  // Shadow copy of the controller state and its registers.
  lcgc_cfg_t   crossing_cfg = CFG_RESET;
  logic        run_started  = 1'b0;
  logic [2:0]  gate_phase   = PHASE_CODE_OPEN;
  logic [2:0]  prev_phase   = PHASE_CODE_OPEN;
  logic [4:0]  phase_ticks  = '0;
  logic [3:0]  raise_mask   = '0;
  lcgc_angle_t arm_angle[NUM_ARMS] = '{default: ANGLE_RESET};
  lamp_state_e lamp         = LAMP_GREEN;
  logic [2:0]  lamp_ticks   = '0;
  logic        arms_down    = 1'b0;
  logic        arms_up_seen = 1'b0;
  logic        alarm_on     = 1'b0;

  level_crossing_gate_controller u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(99) < 14);
  end

  function automatic void bump_ticks();
    if (phase_ticks < COUNT_MAX) phase_ticks = phase_ticks + 1'b1;
    else phase_ticks = COUNT_MAX;
  endfunction

  function automatic void begin_reopen();
    gate_phase  = PHASE_CODE_REOPEN;
    raise_mask  = RAISE_ALL;
    prev_phase  = PHASE_CODE_REOPEN;
    phase_ticks = '0;
    alarm_on    = 1'b0;
  endfunction

  function automatic void begin_closewait();
    gate_phase  = PHASE_CODE_CLOSEWAIT;
    phase_ticks = '0;
    prev_phase  = PHASE_CODE_CLOSEWAIT;
    alarm_on    = 1'b0;
  endfunction

  function automatic void advance_gate(logic ent, logic ext);
    case (gate_phase)
      PHASE_CODE_CLOSED: begin
        raise_mask &= ~(RAISE_LN | RAISE_RS);
        if (ext) begin_reopen();
        else bump_ticks();
      end
      PHASE_CODE_REOPEN: begin
        raise_mask = RAISE_ALL;
        if (arms_up_seen) begin
          gate_phase = PHASE_CODE_OPEN;
          prev_phase = PHASE_CODE_OPEN;
          alarm_on   = 1'b0;
        end else if (phase_ticks > crossing_cfg.fault_timeout) begin
          gate_phase = PHASE_CODE_FAULT;
          alarm_on   = 1'b1;
        end else begin
          bump_ticks();
        end
      end
      PHASE_CODE_OPEN: begin
        raise_mask = RAISE_ALL;
        if (ent) begin
          gate_phase  = PHASE_CODE_ENTERING;
          raise_mask &= ~(RAISE_LS | RAISE_RN);
          prev_phase  = PHASE_CODE_ENTERING;
          phase_ticks = '0;
          alarm_on    = 1'b0;
        end
      end
      PHASE_CODE_FAULT: begin
        if (prev_phase == PHASE_CODE_ENTERING && arms_down) begin_closewait();
        else if (prev_phase == PHASE_CODE_CLOSED && ext) begin_reopen();
        else alarm_on = 1'b1;
      end
      PHASE_CODE_CLOSEWAIT: begin
        if (phase_ticks > crossing_cfg.close_wait) begin
          gate_phase  = PHASE_CODE_CLOSED;
          raise_mask &= ~(RAISE_LN | RAISE_RS);
          phase_ticks = '0;
          prev_phase  = PHASE_CODE_CLOSED;
          alarm_on    = 1'b0;
        end else begin
          bump_ticks();
        end
      end
      // Entering, and the two codes that are never produced.
      default: begin
        raise_mask &= ~(RAISE_LS | RAISE_RN);
        if (phase_ticks > crossing_cfg.fault_timeout) begin
          gate_phase = PHASE_CODE_FAULT;
          alarm_on   = 1'b1;
        end else if (arms_down) begin
          begin_closewait();
        end else begin
          bump_ticks();
        end
      end
    endcase
  endfunction

  function automatic lcgc_angle_t ramp_arm(lcgc_angle_t angle, logic up);
    int v;
    v = up ? int'(angle) + int'(crossing_cfg.ramp_step)
           : int'(angle) - int'(crossing_cfg.ramp_step);
    if (v > int'(crossing_cfg.open_angle)) v = int'(crossing_cfg.open_angle);
    else if (v < 0) v = 0;
    return lcgc_angle_t'(v);
  endfunction

  function automatic void advance_lamp(logic ent, logic ext);
    case (lamp)
      LAMP_GREEN: begin
        if (ent) begin
          lamp       = LAMP_DELAY;
          lamp_ticks = '0;
        end
      end
      LAMP_RED: begin
        if (ext) lamp = LAMP_CLEARING;
      end
      LAMP_DELAY: begin
        if (lamp_ticks >= crossing_cfg.light_delay) lamp = LAMP_RED;
        else lamp_ticks = lamp_ticks + 1'b1;
      end
      default: begin
        if (arm_angle[ARM_RN] >= crossing_cfg.open_threshold &&
            arm_angle[ARM_RS] >= crossing_cfg.open_threshold &&
            arm_angle[ARM_LN] >= crossing_cfg.open_threshold &&
            arm_angle[ARM_LS] >= crossing_cfg.open_threshold) begin
          lamp         = LAMP_GREEN;
          arms_up_seen = 1'b1;
        end
      end
    endcase
  endfunction

  function automatic lcgc_out_t step_crossing(lcgc_in_t t);
    lcgc_out_t r;
    logic      first;
    first = !run_started;
    // The first tick after reset only starts the charts; detectors are ignored.
    if (first) begin
      gate_phase = PHASE_CODE_OPEN;
      raise_mask = RAISE_ALL;
      prev_phase = PHASE_CODE_OPEN;
      alarm_on   = 1'b0;
    end else begin
      advance_gate(t.train_entered, t.train_exited);
    end
    for (int k = 0; k < NUM_ARMS; k++) arm_angle[k] = ramp_arm(arm_angle[k], raise_mask[k]);
    if (first) lamp = LAMP_GREEN;
    else advance_lamp(t.train_entered, t.train_exited);
    run_started = 1'b1;
    arms_down = arm_angle[ARM_RN] < crossing_cfg.closed_threshold &&
                arm_angle[ARM_LS] < crossing_cfg.closed_threshold;
    r.angle_right_north = arm_angle[ARM_RN];
    r.angle_right_south = arm_angle[ARM_RS];
    r.angle_left_north  = arm_angle[ARM_LN];
    r.angle_left_south  = arm_angle[ARM_LS];
    r.light_code        = (lamp == LAMP_GREEN) ? LIGHT_GREEN :
                          (lamp == LAMP_RED)   ? LIGHT_RED   : LIGHT_AMBER;
    r.gate_phase_out    = gate_phase;
    r.alarm_out         = alarm_on;
    return r;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [6:0] data);
    case (idx)
      CFG_RAMP_STEP:        crossing_cfg.ramp_step        = data;
      CFG_OPEN_ANGLE:       crossing_cfg.open_angle       = data;
      CFG_FAULT_TIMEOUT:    crossing_cfg.fault_timeout    = data[4:0];
      CFG_CLOSE_WAIT:       crossing_cfg.close_wait       = data[4:0];
      CFG_LIGHT_DELAY:      crossing_cfg.light_delay      = data[2:0];
      CFG_OPEN_THRESHOLD:   crossing_cfg.open_threshold   = data;
      CFG_CLOSED_THRESHOLD: crossing_cfg.closed_threshold = data;
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string name, logic [6:0] want, logic [6:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    lcgc_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outputs.size() == 0) begin
        $error("result transfer with nothing expected: %p", out_data_o);
        fail_count++;
      end else begin
        want = pending_outputs.pop_front();
        compare_field("angle_right_north", want.angle_right_north,
                      out_data_o.angle_right_north);
        compare_field("angle_right_south", want.angle_right_south,
                      out_data_o.angle_right_south);
        compare_field("angle_left_north", want.angle_left_north,
                      out_data_o.angle_left_north);
        compare_field("angle_left_south", want.angle_left_south,
                      out_data_o.angle_left_south);
        compare_field("light_code", 7'(want.light_code), 7'(out_data_o.light_code));
        compare_field("gate_phase_out", 7'(want.gate_phase_out),
                      7'(out_data_o.gate_phase_out));
        compare_field("alarm_out", 7'(want.alarm_out), 7'(out_data_o.alarm_out));
      end
    end
  end

  task automatic send_tick(input logic ent, input logic ext);
    lcgc_in_t t;
    t.train_entered = ent;
    t.train_exited  = ext;
    while (!no_idle && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
    pending_outputs.push_back(step_crossing(t));
    ticks_sent++;
  endtask

  task automatic wait_results_settled();
    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [6:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
  endtask

  // Narrow registers get random upper data bits, which the block must drop.
  task automatic program_gate(input lcgc_cfg_t c);
    wait_results_settled();
    write_reg(CFG_INDEX_UNUSED, 7'($urandom));
    write_reg(CFG_RAMP_STEP, c.ramp_step);
    write_reg(CFG_OPEN_ANGLE, c.open_angle);
    write_reg(CFG_FAULT_TIMEOUT, {2'($urandom), c.fault_timeout});
    write_reg(CFG_CLOSE_WAIT, {2'($urandom), c.close_wait});
    write_reg(CFG_LIGHT_DELAY, {4'($urandom), c.light_delay});
    write_reg(CFG_OPEN_THRESHOLD, c.open_threshold);
    write_reg(CFG_CLOSED_THRESHOLD, c.closed_threshold);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int unsigned pick_edge(int unsigned lo, int unsigned hi);
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll < 2) return lo;
    if (roll < 4) return hi;
    return $urandom_range(hi, lo);
  endfunction

  function automatic lcgc_cfg_t pick_config(cfg_flavor_e flavor);
    lcgc_cfg_t c;
    case (flavor)
      SET_TAME: begin
        c.ramp_step        = 7'($urandom_range(45, 5));
        c.open_angle       = 7'($urandom_range(127, 60));
        c.fault_timeout    = 5'($urandom_range(20, 6));
        c.close_wait       = 5'($urandom_range(10, 0));
        c.light_delay      = 3'($urandom_range(7, 0));
        c.open_threshold   = 7'($urandom_range(c.open_angle, c.open_angle / 2));
        c.closed_threshold = 7'($urandom_range(30, 1));
      end
      SET_FLOOR: begin
        c = '{ramp_step: 7'd1, open_angle: 7'd1, fault_timeout: 5'd0, close_wait: 5'd0,
              light_delay: 3'd0, open_threshold: 7'd0, closed_threshold: 7'd0};
      end
      SET_CEILING: begin
        c = '{ramp_step: 7'd90, open_angle: 7'd127, fault_timeout: 5'd20,
              close_wait: 5'd20, light_delay: 3'd7, open_threshold: 7'd127,
              closed_threshold: 7'd127};
      end
      default: begin
        c.ramp_step        = 7'(pick_edge(1, 90));
        c.open_angle       = 7'(pick_edge(1, 127));
        c.fault_timeout    = 5'(pick_edge(0, 20));
        c.close_wait       = 5'(pick_edge(0, 20));
        c.light_delay      = 3'(pick_edge(0, 7));
        c.open_threshold   = 7'(pick_edge(0, 127));
        c.closed_threshold = 7'(pick_edge(0, 127));
      end
    endcase
    return c;
  endfunction

  task automatic quiet_or_noise();
    if ($urandom_range(99) < 5) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
    else send_tick(1'b0, 1'b0);
  endtask

  // One approach: mostly a clean enter, dwell, exit; sometimes broken or pure noise.
  task automatic drive_train();
    int kind;
    kind = $urandom_range(9);
    repeat ($urandom_range(4)) send_tick(1'b0, 1'b0);
    if (kind <= 6) begin
      repeat ($urandom_range(2, 1)) send_tick(1'b1, 1'b0);
      repeat ($urandom_range(60, 2)) quiet_or_noise();
      send_tick(1'b0, 1'b1);
      repeat ($urandom_range(25)) quiet_or_noise();
    end else if (kind == 7) begin
      repeat ($urandom_range(30, 10)) begin
        send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end else if (kind == 8) begin
      send_tick(1'b1, 1'b0);
      repeat ($urandom_range(30, 5)) quiet_or_noise();
    end else begin
      send_tick(1'b0, 1'b1);
      repeat ($urandom_range(15, 2)) quiet_or_noise();
    end
  endtask

  task automatic test_first_tick();
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  // Closed threshold zero keeps the arms from ever counting as down, so
  // entering runs out of time and latches the alarm.
  task automatic test_entering_fault();
    lcgc_cfg_t c;
    c = CFG_RESET;
    c.ramp_step        = 7'd90;
    c.fault_timeout    = 5'd0;
    c.close_wait       = 5'd0;
    c.light_delay      = 3'd0;
    c.closed_threshold = 7'd0;
    program_gate(c);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic test_recovery_and_pass();
    lcgc_cfg_t c;
    c = crossing_cfg;
    c.closed_threshold = 7'd10;
    program_gate(c);
    repeat (5) send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    repeat (2) send_tick(1'b0, 1'b0);
  endtask

  task automatic test_zero_motion();
    lcgc_cfg_t c;
    c = crossing_cfg;
    c.ramp_step = 7'd0;
    program_gate(c);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    c.ramp_step  = 7'd90;
    c.open_angle = 7'd0;
    program_gate(c);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned seg_end;
    int          seg;
    cfg_flavor_e flavor;
    goal = ticks_sent + TICK_TARGET;
    seg  = 0;
    while (ticks_sent < goal) begin
      case (seg)
        1:       flavor = SET_FLOOR;
        3:       flavor = SET_CEILING;
        default: flavor = (seg % 2 == 0) ? SET_TAME : SET_WILD;
      endcase
      program_gate(pick_config(flavor));
      no_idle = (seg == 4);
      seg_end = ticks_sent + SEGMENT_TICKS;
      while (ticks_sent < seg_end) begin
        drive_train();
        // In the third segment the sender holds off after every approach.
        if (seg == 2 || $urandom_range(19) == 0) wait_results_settled();
      end
      seg++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_tick();
    test_entering_fault();
    test_recovery_and_pass();
    test_zero_motion();
    test_random_traffic();
    wait_results_settled();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lcgc_pkg.sv
rtl/lcgc_gate_ctrl.sv
rtl/lcgc_arm.sv
rtl/lcgc_light.sv
rtl/level_crossing_gate_controller.sv
tb/testbench.sv
